### hdl/s2i_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// s2i_pkg
// Shared constants and types of the string to signed integer converter.
// ---------------------------------------------------------------------------
package s2i_pkg;

  localparam int VALUE_BITS        = 64;
  localparam int MAX_STRING_LENGTH = 4096;
  localparam int COUNT_W           = $clog2(MAX_STRING_LENGTH);
  localparam int OFFSET_W          = 12;
  localparam int CHAR_W            = 8;
  localparam int BASE_W            = 6;
  localparam int DIGIT_W           = 6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;

  // A classified byte as it travels from the front end to the parser.
  typedef struct packed {
    logic               is_nul;
    logic               is_space;
    logic               is_plus;
    logic               is_minus;
    logic               is_zero;
    logic               is_x;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } cls_t;

endpackage
`default_nettype wire

### hdl/s2i_ifs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// s2i channel interfaces
// Valid/ready channels for bytes, results and base register writes.
// ---------------------------------------------------------------------------
interface s2i_in_if;
  import s2i_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface s2i_out_if;
  import s2i_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] parsed_value;
  logic [OFFSET_W-1:0]          end_offset;
  logic                         saturated;
  modport source (output valid, output parsed_value, output end_offset,
                  output saturated, input ready);
  modport sink (input valid, input parsed_value, input end_offset,
                input saturated, output ready);
endinterface

interface s2i_cfg_if;
  import s2i_pkg::*;
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] number_base;
  modport source (output valid, output number_base, input ready);
  modport sink (input valid, input number_base, output ready);
endinterface
`default_nettype wire

### hdl/s2i_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// s2i_front
// Accepts bytes and classifies them for the parser queue.
// ---------------------------------------------------------------------------
module s2i_front (
  s2i_in_if.sink         in_chan,
  input  logic           queue_full,
  output logic           push,
  output s2i_pkg::cls_t  push_data
);
  import s2i_pkg::*;

  logic [CHAR_W-1:0] c;
  logic              is_num;
  logic              is_uc;
  logic              is_lc;
  logic [CHAR_W-1:0] dval;

  assign c      = in_chan.char_code;
  assign is_num = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_uc  = (c >= CH_UC_A) && (c <= CH_UC_Z);
  assign is_lc  = (c >= CH_LC_A) && (c <= CH_LC_Z);

  always_comb begin
    if (is_num) begin
      dval = c - CH_ZERO;
    end else if (is_lc) begin
      dval = c - CH_LC_A + CHAR_W'(10);
    end else begin
      dval = c - CH_UC_A + CHAR_W'(10);
    end
  end

  assign in_chan.ready = !queue_full;
  assign push          = in_chan.valid && !queue_full;

  always_comb begin
    push_data.is_nul   = (c == CH_NUL);
    push_data.is_space = (c == CH_SPACE) || (c == CH_TAB);
    push_data.is_plus  = (c == CH_PLUS);
    push_data.is_minus = (c == CH_MINUS);
    push_data.is_zero  = (c == CH_ZERO);
    push_data.is_x     = (c == CH_LC_X);
    push_data.is_digit = is_num || is_uc || is_lc;
    push_data.digit    = dval[DIGIT_W-1:0];
  end

endmodule
`default_nettype wire

### hdl/s2i_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// s2i_queue
// Short FIFO of classified bytes between the front end and the parser.
// ---------------------------------------------------------------------------
module s2i_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  s2i_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output s2i_pkg::cls_t head
);
  import s2i_pkg::*;

  cls_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/s2i_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// s2i_back
// Parser state machine with the multiply-add accumulator and result register.
// ---------------------------------------------------------------------------
module s2i_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [s2i_pkg::BASE_W-1:0]  number_base,
  input  logic                        empty,
  input  s2i_pkg::cls_t               head,
  output logic                        pop,
  s2i_out_if.source                   out_chan
);
  import s2i_pkg::*;

  localparam int PROD_W = VALUE_BITS + BASE_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_STRING_LENGTH - 1);
  localparam logic [PROD_W-1:0]  HALF      = PROD_W'(1) << (VALUE_BITS - 1);
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [5:0] {
    PH_SPACE   = 6'b000001,
    PH_SIGNED  = 6'b000010,
    PH_ZERO    = 6'b000100,
    PH_DIGITS  = 6'b001000,
    PH_STOPPED = 6'b010000,
    PH_SAT     = 6'b100000
  } phase_t;

  function automatic logic [COUNT_W-1:0] count_add(input logic [COUNT_W-1:0] c,
                                                   input logic [1:0] n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + (COUNT_W+1)'(n);
    if (s > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return s[COUNT_W-1:0];
  endfunction

  phase_t               phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic [OFFSET_W-1:0]  out_offset_r, out_offset_nxt;
  logic                 out_sat_r;

  logic [BASE_W-1:0]    tb;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    limit;
  logic                 stop;
  logic                 over;
  logic                 do_take;
  logic [1:0]           inc;
  logic [COUNT_W-1:0]   final_count;

  // A terminator needs the result register; any other byte can always go.
  assign pop = !empty && (!head.is_nul || !out_valid_r || out_chan.ready);

  // Base that applies to a digit taken in the current phase.
  always_comb begin
    unique case (phase_r)
      PH_SPACE, PH_SIGNED: tb = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
      PH_ZERO:             tb = (base_r == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      default:             tb = base_r;
    endcase
  end

  assign prod  = PROD_W'(acc_r) * PROD_W'(tb) + PROD_W'(head.digit);
  assign limit = neg_r ? HALF : HALF - PROD_W'(1);
  assign stop  = !head.is_digit || (head.digit >= tb) || (tb == BASE_AUTO);
  assign over  = prod > limit;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    base_nxt  = base_r;
    ovf_nxt   = ovf_r;
    do_take   = 1'b0;
    inc       = 2'd0;
    if (pop && !head.is_nul) begin
      unique case (phase_r)
        PH_SPACE, PH_SIGNED: begin
          if (phase_r == PH_SPACE && head.is_space) begin
            inc = 2'd1;
          end else if (phase_r == PH_SPACE && (head.is_plus || head.is_minus)) begin
            inc       = 2'd1;
            neg_nxt   = head.is_minus;
            phase_nxt = PH_SIGNED;
          end else if ((number_base == BASE_AUTO || number_base == BASE_HEX)
                       && head.is_zero) begin
            base_nxt  = number_base;
            phase_nxt = PH_ZERO;
          end else begin
            base_nxt = tb;
            do_take  = 1'b1;
          end
        end
        PH_ZERO: begin
          if (head.is_x) begin
            inc       = 2'd2;
            base_nxt  = BASE_HEX;
            phase_nxt = PH_DIGITS;
          end else begin
            // The leading zero counts as consumed before the next byte is tried.
            inc      = 2'd1;
            base_nxt = tb;
            do_take  = 1'b1;
          end
        end
        PH_DIGITS: do_take = 1'b1;
        default: ;
      endcase
      if (do_take) begin
        if (stop) begin
          phase_nxt = PH_STOPPED;
        end else if (over) begin
          phase_nxt = PH_SAT;
          ovf_nxt   = 1'b1;
        end else begin
          acc_nxt   = prod[VALUE_BITS-1:0];
          inc       = inc + 2'd1;
          phase_nxt = PH_DIGITS;
        end
      end
    end
    count_nxt = count_add(count_r, inc);
  end

  // Result of a string, formed when its terminator leaves the queue.
  always_comb begin
    final_count = count_add(count_r, (phase_r == PH_ZERO) ? 2'd1 : 2'd0);
    if (ovf_r) begin
      out_value_nxt  = neg_r ? VAL_MIN : VAL_MAX;
      out_offset_nxt = '0;
    end else begin
      out_value_nxt  = neg_r ? ('0 - acc_r) : acc_r;
      out_offset_nxt = OFFSET_W'(final_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      base_r      <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && head.is_nul) begin
        phase_r     <= PH_SPACE;
        acc_r       <= '0;
        neg_r       <= 1'b0;
        base_r      <= '0;
        count_r     <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
        if (out_chan.ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.is_nul) begin
      out_value_r  <= out_value_nxt;
      out_offset_r <= out_offset_nxt;
      out_sat_r    <= ovf_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.parsed_value = out_value_r;
  assign out_chan.end_offset   = out_offset_r;
  assign out_chan.saturated    = out_sat_r;

endmodule
`default_nettype wire

### hdl/string_to_signed_integer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// string_to_signed_integer_top
// Converts a byte stream holding NUL-terminated strings to signed integers.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan carries one byte per transfer. Every NUL byte ends a string and
//   produces one transfer on out_chan with the value, the end offset and the
//   saturation flag; other bytes produce nothing.
//   cfg_chan writes the number base (0 detects the radix from the prefix).
//   It is always ready and should only be written while no string is open.
// Throughput is one byte per cycle while the queue is not full. A NUL accepted
// on in_chan is written into the four-entry byte queue; when it leaves the
// queue the parser loads its result into the output register. The 64 by 6 bit
// multiply-add handles one byte per cycle.
// Reset sets the base to 10, empties the queue and returns the parser to
// its leading-whitespace state.
// When the receiver stalls, the result is held in the output register while
// ordinary bytes keep being parsed; a following NUL waits in the queue, and
// in_chan stops taking bytes once the queue is full.
// ---------------------------------------------------------------------------
module string_to_signed_integer_top (
  input  logic      clk,
  input  logic      rst_n,
  s2i_in_if.sink    in_chan,
  s2i_out_if.source out_chan,
  s2i_cfg_if.sink   cfg_chan
);
  import s2i_pkg::*;

  logic [BASE_W-1:0] base_r;
  logic              push;
  cls_t              push_data;
  logic              queue_full;
  logic              pop;
  logic              empty;
  cls_t              head;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_chan.valid) begin
      base_r <= cfg_chan.number_base;
    end
  end

  s2i_front u_front (
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  s2i_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  s2i_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .number_base (base_r),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule
`default_nettype wire
